>>> hdl/pixel_format_to_luma_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the luma unit
// ---------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_TO_LUMA_UNIT_ASSERT_SVH
`define PIXEL_FORMAT_TO_LUMA_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/pfl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfl_pkg
// Types, codes and the luma weighting shared by the luma unit modules.
// ---------------------------------------------------------------------------
package pfl_pkg;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned DIM_MAX    = (1 << DIM_W) - 1;
  localparam int unsigned FMT_W      = 4;
  localparam int unsigned FIFO_DEPTH = 2;  // power of two

  localparam logic [7:0] WEIGHT_R = 8'd77;
  localparam logic [7:0] WEIGHT_G = 8'd150;
  localparam logic [7:0] WEIGHT_B = 8'd29;

  typedef enum logic [1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } pfl_cfg_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_LUMA     = 4'd0,
    FMT_RGBA     = 4'd1,
    FMT_BGRA     = 4'd2,
    FMT_ARGB     = 4'd3,
    FMT_ABGR     = 4'd4,
    FMT_RGB      = 4'd5,
    FMT_BGR      = 4'd6,
    FMT_Y_FIRST  = 4'd7,
    FMT_Y_SECOND = 4'd8,
    FMT_565      = 4'd9,
    FMT_5551     = 4'd10,
    FMT_4444     = 4'd11
  } pfl_fmt_e;

  // One assembled pixel on its way to the weighting stage.
  typedef struct packed {
    pfl_fmt_e        fmt;
    logic [3:0][7:0] bytes;
    logic            last;
  } pfl_pix_t;

  function automatic logic [7:0] pfl_weigh(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    logic [15:0] sum;
    sum = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
    return sum[15:8];
  endfunction

  function automatic logic [7:0] pfl_luma(input pfl_pix_t p);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] y;
    b0 = p.bytes[0];
    b1 = p.bytes[1];
    b2 = p.bytes[2];
    b3 = p.bytes[3];
    case (p.fmt)
      FMT_LUMA:     y = b0;
      FMT_RGBA:     y = pfl_weigh(b0, b1, b2);
      FMT_BGRA:     y = pfl_weigh(b2, b1, b0);
      FMT_ARGB:     y = pfl_weigh(b1, b2, b3);
      FMT_ABGR:     y = pfl_weigh(b3, b2, b1);
      FMT_RGB:      y = pfl_weigh(b0, b1, b2);
      FMT_BGR:      y = pfl_weigh(b2, b1, b0);
      FMT_Y_FIRST:  y = b0;
      FMT_Y_SECOND: y = b1;
      // Packed formats: widen each field and add half a step (a quarter step for 5551 green).
      FMT_565:  y = pfl_weigh({b0[7:3], 3'b100}, {b0[2:0], b1[7:5], 2'b10},
                              {b1[4:0], 3'b100});
      FMT_5551: y = pfl_weigh({b0[7:3], 3'b100}, {b0[2:0], b1[7:6], 3'b010},
                              {b1[5:1], 3'b100});
      default:  y = pfl_weigh({b0[7:4], 4'b1000}, {b0[3:0], 4'b1000},
                              {b1[7:4], 4'b1000});
    endcase
    return y;
  endfunction

endpackage

>>> hdl/pfl_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfl_front
// Holds configuration, assembles bytes into pixels and counts pixels.
// ---------------------------------------------------------------------------
module pfl_front #(
  parameter int unsigned MAX_FRAME_WIDTH  = 4096,
  parameter int unsigned MAX_FRAME_HEIGHT = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [pfl_pkg::DIM_W-1:0] cfg_wdata_i,
  input  logic                     push_i,
  input  logic [7:0]               in_byte_i,
  input  logic                     frame_start_i,
  input  logic                     fifo_full_i,
  output logic                     pix_push_o,
  output pfl_pkg::pfl_pix_t        pix_o
);
  import pfl_pkg::*;

  localparam int unsigned W_LIM   = (MAX_FRAME_WIDTH < DIM_MAX) ? MAX_FRAME_WIDTH : DIM_MAX;
  localparam int unsigned H_LIM   = (MAX_FRAME_HEIGHT < DIM_MAX) ? MAX_FRAME_HEIGHT : DIM_MAX;
  localparam int unsigned W_RST   = (W_LIM < 640) ? W_LIM : 640;
  localparam int unsigned H_RST   = (H_LIM < 480) ? H_LIM : 480;
  localparam int unsigned TOT_W   = $clog2(W_LIM * H_LIM + 1);
  localparam int unsigned TOT_RST = W_RST * H_RST;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [FMT_W-1:0]     fmt_q;
  logic [DIM_W-1:0]     width_q, height_q;
  logic [TOT_W-1:0]     total_q, total_d;
  logic [1:0]           slot_q, slot_d;
  logic [7:0]           held_q [3];
  logic [7:0]           held_d [3];
  logic [TOT_W-1:0]     idx_q, idx_d;

  logic [DIM_W-1:0]     wdata_w, wdata_h;
  logic [DIM_W-1:0]     mul_a, mul_b;
  logic [2*DIM_W-1:0]   prod;
  logic                 total_we;

  logic                 accept;
  logic                 fmt_known;
  logic [1:0]           last_pos;
  logic [1:0]           slot_eff;
  logic [TOT_W-1:0]     idx_eff;
  logic [TOT_W:0]       idx_inc;
  logic                 is_last;

  // Frame size product, formed from the write data so it is ready at once.
  assign wdata_w = clamp_dim(cfg_wdata_i, DIM_W'(W_LIM));
  assign wdata_h = clamp_dim(cfg_wdata_i, DIM_W'(H_LIM));

  always_comb begin
    mul_a    = width_q;
    mul_b    = height_q;
    total_we = 1'b0;
    case (pfl_cfg_e'(cfg_idx_i))
      CFG_WIDTH: begin
        mul_a    = wdata_w;
        total_we = cfg_we_i;
      end
      CFG_HEIGHT: begin
        mul_b    = wdata_h;
        total_we = cfg_we_i;
      end
      default: begin
        total_we = 1'b0;
      end
    endcase
  end

  assign prod    = (2*DIM_W)'(mul_a) * (2*DIM_W)'(mul_b);
  assign total_d = prod[TOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_LUMA;
      width_q  <= DIM_W'(W_RST);
      height_q <= DIM_W'(H_RST);
      total_q  <= TOT_W'(TOT_RST);
    end else begin
      if (cfg_we_i && (pfl_cfg_e'(cfg_idx_i) == CFG_FORMAT)) begin
        fmt_q <= cfg_wdata_i[FMT_W-1:0];
      end
      if (cfg_we_i && (pfl_cfg_e'(cfg_idx_i) == CFG_WIDTH)) begin
        width_q <= wdata_w;
      end
      if (cfg_we_i && (pfl_cfg_e'(cfg_idx_i) == CFG_HEIGHT)) begin
        height_q <= wdata_h;
      end
      if (total_we) begin
        total_q <= total_d;
      end
    end
  end

  // Position of the byte that completes a pixel.
  always_comb begin
    fmt_known = 1'b1;
    last_pos  = 2'd0;
    case (pfl_fmt_e'(fmt_q))
      FMT_LUMA:                                     last_pos = 2'd0;
      FMT_RGBA, FMT_BGRA, FMT_ARGB, FMT_ABGR:       last_pos = 2'd3;
      FMT_RGB, FMT_BGR:                             last_pos = 2'd2;
      FMT_Y_FIRST, FMT_Y_SECOND, FMT_565, FMT_5551,
      FMT_4444:                                     last_pos = 2'd1;
      default:                                      fmt_known = 1'b0;
    endcase
  end

  assign accept   = push_i && !fifo_full_i;
  assign slot_eff = frame_start_i ? 2'd0 : slot_q;
  assign idx_eff  = frame_start_i ? '0 : idx_q;
  assign idx_inc  = {1'b0, idx_eff} + (TOT_W+1)'(1);
  assign is_last  = idx_inc >= {1'b0, total_q};

  always_comb begin
    pix_o.fmt   = pfl_fmt_e'(fmt_q);
    pix_o.last  = is_last;
    pix_o.bytes = {8'd0, held_q[2], held_q[1], held_q[0]};
    pix_o.bytes[last_pos] = in_byte_i;
  end

  always_comb begin
    slot_d     = slot_q;
    held_d     = held_q;
    idx_d      = idx_q;
    pix_push_o = 1'b0;
    if (accept) begin
      idx_d = idx_eff;
      if (!fmt_known) begin
        // Drop the byte and restart the pixel.
        slot_d = 2'd0;
      end else if (slot_eff < last_pos) begin
        held_d[slot_eff] = in_byte_i;
        slot_d           = slot_eff + 2'd1;
      end else begin
        pix_push_o = 1'b1;
        slot_d     = 2'd0;
        idx_d      = is_last ? '0 : idx_inc[TOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 2'd0;
      held_q <= '{default: 8'd0};
      idx_q  <= '0;
    end else begin
      slot_q <= slot_d;
      held_q <= held_d;
      idx_q  <= idx_d;
    end
  end

endmodule

>>> hdl/pfl_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfl_fifo
// Short pixel queue between the assembly front and the weighting back.
// ---------------------------------------------------------------------------
module pfl_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfl_pkg::pfl_pix_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output pfl_pkg::pfl_pix_t rdata_o
);
  import pfl_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  pfl_pix_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hdl/pfl_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfl_back
// Weights the queued pixel into luma and holds it in the result register.
// ---------------------------------------------------------------------------
module pfl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfl_pkg::pfl_pix_t head_i,
  input  logic              head_valid_i,
  output logic              head_pop_o,
  output logic [7:0]        luma_o,
  output logic              last_of_frame_o,
  output logic              empty_o,
  input  logic              pop_i
);
  import pfl_pkg::*;

  logic       valid_q;
  logic [7:0] luma_q, luma_d;
  logic       last_q;

  // Refill the result register when it is free or being drained this cycle.
  assign head_pop_o = head_valid_i && (!valid_q || pop_i);
  assign luma_d     = pfl_luma(head_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (head_pop_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_pop_o) begin
      luma_q <= luma_d;
      last_q <= head_i.last;
    end
  end

  assign empty_o         = !valid_q;
  assign luma_o          = luma_q;
  assign last_of_frame_o = last_q;

endmodule

>>> hdl/pixel_format_to_luma_unit.sv
`timescale 1ns / 1ps
// The byte that completes a pixel goes into the pixel queue, then into the result register once it is free.
// Throughput: one byte per cycle while the pixel queue is not full; full stalls the input.
// Bytes that do not complete a pixel, and bytes of an unknown format, give no result.
// Reset: queue, byte slot, held bytes and pixel counter clear; format is luma copy, 640x480.
// ---------------------------------------------------------------------------
// pixel_format_to_luma_unit
// Byte-stream to luma converter: front assembly, pixel queue, weighting back.
// ---------------------------------------------------------------------------
module pixel_format_to_luma_unit #(
  parameter int unsigned MAX_FRAME_WIDTH  = 4096,
  parameter int unsigned MAX_FRAME_HEIGHT = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [pfl_pkg::DIM_W-1:0] cfg_wdata_i,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                in_byte_i,
  input  logic                      frame_start_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                luma_o,
  output logic                      last_of_frame_o
);
  import pfl_pkg::*;

  `include "pixel_format_to_luma_unit_assert.svh"

  logic     pix_push;
  pfl_pix_t pix;
  logic     fifo_full;
  logic     fifo_empty;
  logic     fifo_pop;
  pfl_pix_t head;

  pfl_front #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push_i        (push),
    .in_byte_i     (in_byte_i),
    .frame_start_i (frame_start_i),
    .fifo_full_i   (fifo_full),
    .pix_push_o    (pix_push),
    .pix_o         (pix)
  );

  pfl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pix_push),
    .wdata_i (pix),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .rdata_o (head)
  );

  pfl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (!fifo_empty),
    .head_pop_o      (fifo_pop),
    .luma_o          (luma_o),
    .last_of_frame_o (last_of_frame_o),
    .empty_o         (empty),
    .pop_i           (pop)
  );

  assign full = fifo_full;

  `PFL_ASSERT_NOW(a_no_push_when_full, pix_push, !fifo_full, "pixel pushed into full queue")
  `PFL_ASSERT_NEXT(a_result_follows_queue, !fifo_empty && (empty || pop), !empty,
                   "queued pixel did not reach the result register")
  `PFL_ASSERT_NEXT(a_drain_to_empty, pop && !empty && fifo_empty, empty,
                   "result register refilled from an empty queue")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Luma unit check: a short table of hand-picked bytes and register writes,
// then random frames, most under random push/pop stalls, every result compared
// against its table value or an in-bench pixel assembler and luma weighting.
// ---------------------------------------------------------------------------
module testbench;
  import pfl_pkg::*;

  localparam int unsigned MAX_DIM   = 4096;
  localparam logic [1:0]  CFG_SPARE = 2'd3;  // decoded by nothing

  typedef struct packed {
    logic [7:0] luma;
    logic       last;
  } luma_px_t;

  typedef enum logic {
    ROW_REG,
    ROW_BYTE
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       reg_idx;
    logic [DIM_W-1:0] reg_val;
    logic [7:0]       data;
    logic             sof;
    logic             typed;
    logic [7:0]       luma;
    logic             last;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [DIM_W-1:0] cfg_wdata_i;
  logic             push;
  logic             full;
  logic [7:0]       in_byte_i;
  logic             frame_start_i;
  logic             empty;
  logic             pop;
  logic [7:0]       luma_o;
  logic             last_of_frame_o;

  // Shadow of the unit: registers and pixel assembly state.
  logic [3:0]       fmt_reg    = FMT_LUMA;
  logic [DIM_W-1:0] width_reg  = 13'd640;
  logic [DIM_W-1:0] height_reg = 13'd480;
  logic [1:0]       fill_slot  = 2'd0;
  logic [7:0]       held_byte[3] = '{8'h00, 8'h00, 8'h00};
  logic [23:0]      frame_pos  = 24'd0;

  luma_px_t  pending_luma[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  bit        no_stall = 1'b0;

  pixel_format_to_luma_unit #(
    .MAX_FRAME_WIDTH (MAX_DIM),
    .MAX_FRAME_HEIGHT(MAX_DIM)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .frame_start_i  (frame_start_i),
    .empty          (empty),
    .pop            (pop),
    .luma_o         (luma_o),
    .last_of_frame_o(last_of_frame_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned pixel_bytes(input logic [3:0] fmt);
    case (fmt)
      FMT_LUMA:                                          return 1;
      FMT_RGBA, FMT_BGRA, FMT_ARGB, FMT_ABGR:            return 4;
      FMT_RGB, FMT_BGR:                                  return 3;
      FMT_Y_FIRST, FMT_Y_SECOND, FMT_565, FMT_5551, FMT_4444: return 2;
      default:                                           return 0;
    endcase
  endfunction

  function automatic logic [7:0] weigh_rgb(input int unsigned r, input int unsigned g,
                                           input int unsigned b);
    int unsigned sum;
    sum = 77 * r + 150 * g + 29 * b;
    return 8'(sum >> 8);
  endfunction

  function automatic logic [7:0] pixel_luma(input logic [3:0] fmt, input logic [3:0][7:0] px);
    int unsigned b0;
    int unsigned b1;
    b0 = px[0];
    b1 = px[1];
    case (fmt)
      FMT_LUMA, FMT_Y_FIRST: return px[0];
      FMT_Y_SECOND:          return px[1];
      FMT_RGBA, FMT_RGB:     return weigh_rgb(px[0], px[1], px[2]);
      FMT_BGRA, FMT_BGR:     return weigh_rgb(px[2], px[1], px[0]);
      FMT_ARGB:              return weigh_rgb(px[1], px[2], px[3]);
      FMT_ABGR:              return weigh_rgb(px[3], px[2], px[1]);
      // Packed formats: widen each field, then add half a step of it (a quarter step for 5551 green).
      FMT_565:
        return weigh_rgb((b0 & 'hf8) + 4, ((b0 & 'h07) << 5) + ((b1 & 'he0) >> 3) + 2,
                         ((b1 & 'h1f) << 3) + 4);
      FMT_5551:
        return weigh_rgb((b0 & 'hf8) + 4, ((b0 & 'h07) << 5) + ((b1 & 'hc0) >> 3) + 2,
                         ((b1 & 'h3e) << 2) + 4);
      default:
        return weigh_rgb((b0 & 'hf0) + 8, ((b0 & 'h0f) << 4) + 8, (b1 & 'hf0) + 8);
    endcase
  endfunction

  function automatic int unsigned dim_of(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Take one byte into the shadow; returns 1 when it completes a pixel.
  function automatic bit assemble_pixel(input logic [7:0] data, input logic sof,
                                        output luma_px_t res);
    int unsigned     depth;
    int unsigned     last_pos;
    int unsigned     total;
    logic [3:0][7:0] px;
    res = '0;
    if (sof) begin
      fill_slot = 2'd0;
      frame_pos = 24'd0;
    end
    depth = pixel_bytes(fmt_reg);
    if (depth == 0) begin
      fill_slot = 2'd0;
      return 1'b0;
    end
    last_pos = depth - 1;
    if (fill_slot < last_pos) begin
      held_byte[fill_slot] = data;
      fill_slot++;
      return 1'b0;
    end
    // A slot past the end (format shrank mid-pixel) still lands on the last byte.
    px = {8'h00, held_byte[2], held_byte[1], held_byte[0]};
    px[last_pos] = data;
    total = dim_of(width_reg) * dim_of(height_reg);
    res.last = (frame_pos + 1 >= total);
    frame_pos = res.last ? 24'd0 : frame_pos + 24'd1;
    fill_slot = 2'd0;
    res.luma = pixel_luma(fmt_reg, px);
    return 1'b1;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input int unsigned val);
    plan_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = DIM_W'(val);
    return r;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] data, input logic sof);
    plan_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.data = data;
    r.sof  = sof;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [7:0] data, input logic sof,
                                          input logic [7:0] luma, input logic last);
    plan_row_t r;
    r = byte_row(data, sof);
    r.typed = 1'b1;
    r.luma  = luma;
    r.last  = last;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] pick_format();
    logic [DIM_W-1:0] v;
    v = DIM_W'($urandom);
    if ($urandom_range(11) == 0) v[3:0] = 4'($urandom_range(2**FMT_W - 1, FMT_4444 + 1));
    else v[3:0] = 4'($urandom_range(FMT_4444, FMT_LUMA));
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(19))
      0:       return '0;
      1:       return DIM_W'(MAX_DIM);
      2:       return DIM_W'($urandom_range(2**DIM_W - 1, MAX_DIM + 1));
      3:       return DIM_W'($urandom_range(64, 2));
      default: return DIM_W'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s expected %02h actual %02h", $time, what, want, got);
  endtask

  // Hold off until every expected pixel is out and the pipe has emptied.
  task automatic settle();
    push     <= 1'b0;
    cfg_we_i <= 1'b0;
    while (pending_luma.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_FORMAT: fmt_reg    = val[3:0];
      CFG_WIDTH:  width_reg  = val;
      CFG_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic feed_byte(input logic [7:0] data, input logic sof, input logic typed,
                           input logic [7:0] luma, input logic last);
    luma_px_t res;
    bit       got;
    cfg_we_i <= 1'b0;
    while (!no_stall && $urandom_range(99) < 19) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    in_byte_i     <= data;
    frame_start_i <= sof;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    got = assemble_pixel(data, sof, res);
    if (typed) begin
      got      = 1'b1;
      res.luma = luma;
      res.last = last;
    end
    if (got) pending_luma.push_back(res);
  endtask

  // Result side: pop at random, check each transfer against the oldest pixel.
  initial begin
    luma_px_t want;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_luma.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t ns: no result expected, got luma %02h last %0b",
                     $time, luma_o, last_of_frame_o);
        end else begin
          want = pending_luma.pop_front();
          if (luma_o !== want.luma) flag_mismatch("luma", want.luma, luma_o);
          if (last_of_frame_o !== want.last)
            flag_mismatch("last_of_frame", want.last, last_of_frame_o);
        end
      end
      pop <= no_stall || ($urandom_range(99) >= 19);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned phase;
    logic        sof;

    push          <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_FORMAT;
    cfg_wdata_i   <= '0;
    in_byte_i     <= 8'h00;
    frame_start_i <= 1'b0;

    // Out of reset: luma copy at 640x480, so nothing is last yet.
    plan.push_back(known_row(8'h00, 1'b1, 8'h00, 1'b0));
    // Shrink to 1x1 (zero reads as one) with the counter already past it.
    plan.push_back(reg_row(CFG_WIDTH, 0));
    plan.push_back(reg_row(CFG_HEIGHT, 0));
    plan.push_back(known_row(8'hff, 1'b0, 8'hff, 1'b1));
    plan.push_back(reg_row(CFG_FORMAT, FMT_RGBA));
    plan.push_back(byte_row(8'hff, 1'b0));
    plan.push_back(byte_row(8'hff, 1'b0));
    plan.push_back(byte_row(8'hff, 1'b0));
    plan.push_back(known_row(8'h00, 1'b0, 8'hff, 1'b1));
    // An oversized width saturates; the height is set to the maximum.
    plan.push_back(reg_row(CFG_WIDTH, 2**DIM_W - 1));
    plan.push_back(reg_row(CFG_HEIGHT, MAX_DIM));
    plan.push_back(reg_row(CFG_FORMAT, FMT_BGRA));
    plan.push_back(byte_row(8'h12, 1'b1));
    plan.push_back(byte_row(8'h34, 1'b0));
    plan.push_back(byte_row(8'h56, 1'b0));
    plan.push_back(byte_row(8'h78, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_ARGB));
    plan.push_back(byte_row(8'h00, 1'b0));
    plan.push_back(byte_row(8'hff, 1'b0));
    plan.push_back(byte_row(8'h00, 1'b0));
    plan.push_back(byte_row(8'h80, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_ABGR));
    plan.push_back(byte_row(8'hc3, 1'b0));
    plan.push_back(byte_row(8'h11, 1'b0));
    plan.push_back(byte_row(8'h22, 1'b0));
    plan.push_back(byte_row(8'h33, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_RGB));
    plan.push_back(byte_row(8'h00, 1'b0));
    plan.push_back(byte_row(8'h00, 1'b0));
    plan.push_back(known_row(8'h00, 1'b0, 8'h00, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_BGR));
    plan.push_back(byte_row(8'h80, 1'b0));
    plan.push_back(byte_row(8'h40, 1'b0));
    plan.push_back(byte_row(8'h20, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_Y_FIRST));
    plan.push_back(byte_row(8'h9e, 1'b0));
    plan.push_back(known_row(8'h01, 1'b0, 8'h9e, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_Y_SECOND));
    plan.push_back(byte_row(8'h01, 1'b0));
    plan.push_back(known_row(8'h9e, 1'b0, 8'h9e, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_565));
    plan.push_back(byte_row(8'hff, 1'b0));
    plan.push_back(byte_row(8'hff, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_5551));
    plan.push_back(byte_row(8'hab, 1'b0));
    plan.push_back(byte_row(8'hcd, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_4444));
    plan.push_back(byte_row(8'h0f, 1'b0));
    plan.push_back(byte_row(8'hf0, 1'b0));
    // Unknown format drops the byte.
    plan.push_back(reg_row(CFG_FORMAT, 2**FMT_W - 1));
    plan.push_back(byte_row(8'h77, 1'b0));
    // Switch to a two-byte format with two bytes already held.
    plan.push_back(reg_row(CFG_FORMAT, FMT_RGBA));
    plan.push_back(byte_row(8'h11, 1'b0));
    plan.push_back(byte_row(8'h22, 1'b0));
    plan.push_back(reg_row(CFG_FORMAT, FMT_565));
    plan.push_back(byte_row(8'h33, 1'b0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        feed_byte(plan[i].data, plan[i].sof, plan[i].typed, plan[i].luma, plan[i].last);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < 1550) begin
      no_stall = (phase >= 6 && phase <= 9);
      settle();
      if ($urandom_range(3) != 0) write_reg(CFG_FORMAT, pick_format());
      if ($urandom_range(2) != 0) write_reg(CFG_WIDTH, pick_dim());
      if ($urandom_range(2) != 0) write_reg(CFG_HEIGHT, pick_dim());
      if ($urandom_range(15) == 0) write_reg(CFG_SPARE, DIM_W'($urandom));
      burst = $urandom_range(48, 8);
      for (int k = 0; k < burst; k++) begin
        sof = (k == 0 && $urandom_range(1) == 1) || ($urandom_range(49) == 0);
        feed_byte(pick_byte(), sof, 1'b0, 8'h00, 1'b0);
        sent++;
      end
      phase++;
    end
    no_stall = 1'b0;

    settle();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/pfl_pkg.sv
hdl/pfl_front.sv
hdl/pfl_fifo.sv
hdl/pfl_back.sv
hdl/pixel_format_to_luma_unit.sv
tb/sv/testbench.sv
